// File: hdl/vasm_pkg.sv
`timescale 1ns / 1ps
package vasm_pkg;
    localparam int CHANNELS     = 8;
    localparam int SOUNDS       = 16;
    localparam int SAMPLE_WORDS = 65536;
    localparam int CH_W   = $clog2(CHANNELS);
    localparam int SND_W  = 4;
    localparam int ADDR_W = $clog2(SAMPLE_WORDS);
    localparam int SUM_W  = 12;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_DEFINE = 2'd1,
        OP_START  = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        REG_EFFECTS = 1'd0,
        REG_MUSIC   = 1'd1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
        logic [3:0]  sound_sel;
        logic [7:0]  sound_priority;
        logic [15:0] sound_base;
        logic [15:0] sound_length;
        logic [7:0]  music_sample;
    } in_word_t;

    typedef struct packed {
        logic       kind;
        logic       granted;
        logic [2:0] channel;
        logic [7:0] mixed_sample;
        logic [7:0] active_mask;
    } out_word_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_READ,
        BK_ACC,
        BK_MIX,
        BK_OUT
    } bk_state_t;
endpackage

// File: hdl/vasm_if.sv
`timescale 1ns / 1ps
interface vasm_in_if;
    logic valid;
    logic ready;
    vasm_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vasm_out_if;
    logic valid;
    logic ready;
    vasm_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/voice_allocator_sample_mixer_core.sv
`timescale 1ns / 1ps
// channel   | dir | handshake      | word
// in_ch     | in  | valid / ready  | operation and its operands
// out_ch    | out | valid / ready  | start answer or mixed sample
// cfg       | in  | cfg_we         | cfg_index, cfg_data
// writes and defines end in idle; a start answer or music pass-through goes on to BK_OUT
// a tick scans each channel in turn, with a read and an accumulate state for each
// playing voice (one sample memory read port, registered), then mix and output
// a two-word queue lets the front take words while the back is busy
// rst_n clears voices, sound table and registers; the sample memory is not cleared
// a held result blocks the back part; the queue then fills and drops ready
module voice_allocator_sample_mixer_core (
    input  logic clk,
    input  logic rst_n,
    vasm_in_if.sink in_ch,
    vasm_out_if.source out_ch,
    input  logic cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [0:0] cfg_data
);
    import vasm_pkg::*;

    logic effects_reg, music_reg;
    logic q_valid, q_pop;
    in_word_t q_word;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effects_reg <= 1'b0;
            music_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_EFFECTS: effects_reg <= cfg_data[0];
                REG_MUSIC:   music_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front: accept and buffer words
    vasm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop)
    );

    // back: table, voices, mixer
    vasm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .effects_enable (effects_reg),
        .music_on       (music_reg),
        .q_valid        (q_valid),
        .q_word         (q_word),
        .q_pop          (q_pop),
        .out_ch         (out_ch)
    );
endmodule

// File: hdl/vasm_front.sv
`timescale 1ns / 1ps
module vasm_front (
    input  logic clk,
    input  logic rst_n,
    vasm_in_if.sink in_ch,
    output logic q_valid,
    output vasm_pkg::in_word_t q_word,
    input  logic q_pop
);
    import vasm_pkg::*;

    // short fifo; sample writes and defines pass through it too so order holds
    in_word_t mem_reg [QDEPTH];
    logic wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push;

    assign in_ch.ready = (cnt_reg != 2'(QDEPTH));
    assign push = in_ch.valid && in_ch.ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word = mem_reg[rp_reg];

    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_ch.data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'(QDEPTH) |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QDEPTH)) else $error("queue count out of range");
`endif
endmodule

// File: hdl/vasm_back.sv
`timescale 1ns / 1ps
module vasm_back (
    input  logic clk,
    input  logic rst_n,
    input  logic effects_enable,
    input  logic music_on,
    input  logic q_valid,
    input  vasm_pkg::in_word_t q_word,
    output logic q_pop,
    vasm_out_if.source out_ch
);
    import vasm_pkg::*;

    logic [7:0] smem [SAMPLE_WORDS];
    logic [7:0] rd_reg;

    logic [7:0]  tpri_reg [SOUNDS];
    logic [15:0] tbase_reg [SOUNDS];
    logic [15:0] tlen_reg [SOUNDS];
    logic [CHANNELS-1:0] play_reg, play_next;
    logic [SND_W-1:0] vsnd_reg [CHANNELS];
    logic [15:0] vpos_reg [CHANNELS];

    bk_state_t st_reg, st_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    in_word_t cur_reg, cur_next;
    out_word_t obuf_reg, obuf_next;
    logic ovalid_reg, ovalid_next;

    logic [15:0] vpos_c;
    logic [15:0] vlen_c;
    logic [15:0] rd_addr;
    logic        ch_last;
    logic        do_write, do_define, do_claim, do_adv, do_rel;
    logic [CH_W-1:0] claim_ch;
    logic [CHANNELS-1:0] free_c, pre_c;
    logic        any_free, any_pre;
    logic [CH_W-1:0] free_ch, pre_ch;
    logic [SUM_W-1:0] scaled;
    logic [9:0]  blend;
    logic [7:0]  mix_c;

    assign vpos_c = vpos_reg[ch_reg];
    assign vlen_c = tlen_reg[vsnd_reg[ch_reg]];
    assign rd_addr = tbase_reg[vsnd_reg[ch_reg]] + vpos_c;
    assign ch_last = (ch_reg == CH_W'(CHANNELS - 1));
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = obuf_reg;

    // channel pick for a start: lowest idle, else first preemptable
    always_comb
    begin
        any_free = 1'b0;
        any_pre = 1'b0;
        free_ch = '0;
        pre_ch = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            free_c[c] = !play_reg[c];
            pre_c[c] = tpri_reg[q_word.sound_sel] <= tpri_reg[vsnd_reg[c]];
        end
        for (int c = CHANNELS - 1; c >= 0; c--)
        begin
            if (free_c[c])
            begin
                any_free = 1'b1;
                free_ch = CH_W'(c);
            end
            if (pre_c[c])
            begin
                any_pre = 1'b1;
                pre_ch = CH_W'(c);
            end
        end
    end

    assign scaled = sum_reg >> 4;
    assign blend = (10'(scaled) * 10'd3 + 10'(cur_reg.music_sample)) >> 2;
    assign mix_c = music_on ? blend[7:0] : scaled[7:0];

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE:
            begin
                if (q_valid && !ovalid_reg)
                begin
                    case (op_t'(q_word.operation))
                        OP_TICK:
                            st_next = (!effects_enable && music_on) ? BK_OUT : BK_SCAN;
                        OP_START: st_next = BK_OUT;
                        default:  st_next = BK_IDLE;
                    endcase
                end
            end
            BK_SCAN:
            begin
                if (play_reg[ch_reg] && vpos_c < vlen_c)
                begin
                    st_next = BK_READ;
                end
                else if (ch_last)
                begin
                    st_next = BK_MIX;
                end
            end
            BK_READ: st_next = BK_ACC;
            BK_ACC:  st_next = ch_last ? BK_MIX : BK_SCAN;
            BK_MIX:  st_next = BK_OUT;
            BK_OUT:  st_next = BK_IDLE;
            default: st_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        do_write = 1'b0;
        do_define = 1'b0;
        do_claim = 1'b0;
        do_adv = 1'b0;
        do_rel = 1'b0;
        claim_ch = '0;
        ch_next = ch_reg;
        sum_next = sum_reg;
        cur_next = cur_reg;
        obuf_next = obuf_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        play_next = play_reg;
        case (st_reg)
            BK_IDLE:
            begin
                if (q_valid && !ovalid_reg)
                begin
                    q_pop = 1'b1;
                    cur_next = q_word;
                    ch_next = '0;
                    sum_next = '0;
                    case (op_t'(q_word.operation))
                        OP_WRITE:  do_write = 1'b1;
                        OP_DEFINE: do_define = 1'b1;
                        OP_START:
                        begin
                            obuf_next = '0;
                            if (any_free || any_pre)
                            begin
                                do_claim = 1'b1;
                                claim_ch = any_free ? free_ch : pre_ch;
                                obuf_next.granted = 1'b1;
                                obuf_next.channel = 3'(claim_ch);
                            end
                        end
                        OP_TICK:
                        begin
                            obuf_next = '0;
                            obuf_next.kind = 1'b1;
                            obuf_next.mixed_sample = q_word.music_sample;
                        end
                        default: ;
                    endcase
                end
            end
            BK_SCAN:
            begin
                if (!(play_reg[ch_reg] && vpos_c < vlen_c))
                begin
                    do_rel = play_reg[ch_reg];
                    ch_next = ch_reg + 1'b1;
                end
            end
            BK_ACC:
            begin
                sum_next = sum_reg + SUM_W'(rd_reg);
                do_adv = 1'b1;
                ch_next = ch_reg + 1'b1;
            end
            BK_MIX: obuf_next.mixed_sample = mix_c;
            BK_OUT:
            begin
                obuf_next.active_mask = 8'(play_reg);
                ovalid_next = 1'b1;
            end
            default: ;
        endcase
        if (do_claim)
        begin
            play_next[claim_ch] = 1'b1;
        end
        if (do_rel || (do_adv && (vpos_c + 16'd1) >= vlen_c))
        begin
            play_next[ch_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_IDLE;
            ovalid_reg <= 1'b0;
            play_reg <= '0;
            for (int i = 0; i < SOUNDS; i++)
            begin
                tpri_reg[i] <= '0;
                tbase_reg[i] <= '0;
                tlen_reg[i] <= '0;
            end
            for (int c = 0; c < CHANNELS; c++)
            begin
                vsnd_reg[c] <= '0;
                vpos_reg[c] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            ovalid_reg <= ovalid_next;
            play_reg <= play_next;
            if (do_define)
            begin
                tpri_reg[q_word.sound_sel] <= q_word.sound_priority;
                tbase_reg[q_word.sound_sel] <= q_word.sound_base;
                tlen_reg[q_word.sound_sel] <= q_word.sound_length;
            end
            if (do_claim)
            begin
                vsnd_reg[claim_ch] <= q_word.sound_sel;
                vpos_reg[claim_ch] <= '0;
            end
            if (do_adv)
            begin
                vpos_reg[ch_reg] <= vpos_c + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
        sum_reg <= sum_next;
        cur_reg <= cur_next;
        obuf_reg <= obuf_next;
        if (do_write)
        begin
            smem[q_word.mem_address] <= q_word.mem_data;
        end
        rd_reg <= smem[rd_addr];
    end

`ifndef ASSERT_OFF
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg == BK_IDLE) else $error("pop outside idle");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == BK_OUT |=> ovalid_reg) else $error("result not raised");
    a_read_acc: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == BK_READ |=> st_reg == BK_ACC) else $error("read not followed");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !q_pop) else $error("pop while result pending");
`endif
endmodule
